@@ src/alu8f_pkg.sv @@
// ----------------------------------------------------------------------------
// alu8f_pkg
// Shared types and operation codes for the eight-bit ALU with flags.
// ----------------------------------------------------------------------------
package alu8f_pkg;

  localparam int unsigned KindWidth = 5;

  typedef enum logic [KindWidth-1:0] {
    K_ADD8  = 5'd0,
    K_ADC8  = 5'd1,
    K_SUB8  = 5'd2,
    K_SBC8  = 5'd3,
    K_CMP8  = 5'd4,
    K_OR8   = 5'd5,
    K_XOR8  = 5'd6,
    K_AND8  = 5'd7,
    K_SRL   = 5'd8,
    K_SLL   = 5'd9,
    K_RRC   = 5'd10,
    K_RLC   = 5'd11,
    K_INC   = 5'd12,
    K_DEC   = 5'd13,
    K_TST   = 5'd14,
    K_SRA   = 5'd15,
    K_ROT   = 5'd16,
    K_BOOL  = 5'd17,
    K_MSK   = 5'd18,
    K_MUL   = 5'd19,
    K_MAD   = 5'd20,
    K_ADDW  = 5'd21,
    K_ADCW  = 5'd22,
    K_SUBW  = 5'd23,
    K_SBCW  = 5'd24,
    K_ORW   = 5'd25,
    K_INCW  = 5'd26,
    K_ADCW1 = 5'd27,
    K_SBCW1 = 5'd28,
    K_TSTW  = 5'd29,
    K_NEGW  = 5'd30
  } kind_t;

  typedef struct packed {
    logic z;
    logic n;
    logic c;
    logic o;
    logic h;
  } flags_t;

  localparam flags_t FlagsClear = '{z: 1'b0, n: 1'b0, c: 1'b0, o: 1'b0, h: 1'b0};

endpackage

@@ src/eight_bit_alu_with_flags_core.sv @@
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_core
// Flag-setting ALU: one operation per word, flags kept for carry-in.
// ----------------------------------------------------------------------------
// Datapath: an accepted request goes to the input register, then to the result
// register once that register is free or being emptied.
// Throughput: one word per cycle unless stalled; the flag register feeds back.
// Reset: pipeline valids and the flag register (Z, N, C, O, H) clear.
// Flag outputs show the flag register, which always holds the flags of the
// word in the result register.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [4:0]  kind,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  input  logic [7:0]  operand_c,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output logic [15:0] result,
  output logic        writes_result,
  output logic        flag_zero,
  output logic        flag_negative,
  output logic        flag_carry,
  output logic        flag_overflow,
  output logic        flag_half
);

  logic              in_valid;
  alu8f_pkg::kind_t  in_kind;
  logic [15:0]       in_a;
  logic [15:0]       in_b;
  logic [7:0]        in_c;

  alu8f_pkg::flags_t flags;
  alu8f_pkg::flags_t flags_next;
  logic [15:0]       result_next;
  logic              writes_next;

  logic              advance;
  logic              take;

  // result register free, or being emptied this cycle
  assign advance   = in_valid & (~rsp_valid | ~rsp_stall);
  assign req_stall = in_valid & ~advance;
  assign take      = req_valid & ~req_stall;

  alu8f_exec u_exec (
    .kind          (in_kind),
    .operand_a     (in_a),
    .operand_b     (in_b),
    .operand_c     (in_c),
    .flags_cur     (flags),
    .result        (result_next),
    .writes_result (writes_next),
    .flags_new     (flags_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (take) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_kind <= alu8f_pkg::kind_t'(kind);
      in_a    <= operand_a;
      in_b    <= operand_b;
      in_c    <= operand_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      flags     <= alu8f_pkg::FlagsClear;
    end else if (advance) begin
      rsp_valid <= 1'b1;
      flags     <= flags_next;
    end else if (~rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result        <= result_next;
      writes_result <= writes_next;
    end
  end

  assign flag_zero     = flags.z;
  assign flag_negative = flags.n;
  assign flag_carry    = flags.c;
  assign flag_overflow = flags.o;
  assign flag_half     = flags.h;

endmodule

@@ src/alu8f_exec.sv @@
// ----------------------------------------------------------------------------
// alu8f_exec
// Single-pass datapath: computes result, write-back mark and next flags.
// ----------------------------------------------------------------------------
module alu8f_exec (
  input  alu8f_pkg::kind_t  kind,
  input  logic [15:0]       operand_a,
  input  logic [15:0]       operand_b,
  input  logic [7:0]        operand_c,
  input  alu8f_pkg::flags_t flags_cur,
  output logic [15:0]       result,
  output logic              writes_result,
  output alu8f_pkg::flags_t flags_new
);

  logic [7:0]  al;
  logic [7:0]  bl;
  logic        cin;

  // byte adder
  logic [7:0]  add8_b;
  logic        add8_ci;
  logic [8:0]  sum8;
  logic [4:0]  nib8;
  logic        ovf8;

  // word adder
  logic [15:0] add16_a;
  logic [15:0] add16_b;
  logic        add16_ci;
  logic [16:0] sum16;
  logic        ovf16;

  // multiplier
  logic [7:0]  mul_b;
  logic [15:0] prod;
  logic [15:0] mad_sum;

  logic [15:0] rot_word;
  logic [7:0]  inc8;
  logic [7:0]  dec8;
  logic [7:0]  merge8;

  assign al  = operand_a[7:0];
  assign bl  = operand_b[7:0];
  assign cin = flags_cur.c;

  always_comb begin
    case (kind)
      alu8f_pkg::K_ADC8: begin add8_b = bl;  add8_ci = cin;  end
      alu8f_pkg::K_SUB8: begin add8_b = ~bl; add8_ci = 1'b1; end
      alu8f_pkg::K_SBC8: begin add8_b = ~bl; add8_ci = cin;  end
      alu8f_pkg::K_CMP8: begin add8_b = ~bl; add8_ci = 1'b1; end
      default:           begin add8_b = bl;  add8_ci = 1'b0; end
    endcase
  end

  assign sum8 = {1'b0, al} + {1'b0, add8_b} + {8'd0, add8_ci};
  assign nib8 = {1'b0, al[3:0]} + {1'b0, add8_b[3:0]} + {4'd0, add8_ci};
  assign ovf8 = (al[7] & add8_b[7] & ~sum8[7]) | (~al[7] & ~add8_b[7] & sum8[7]);

  always_comb begin
    add16_a  = operand_a;
    add16_b  = operand_b;
    add16_ci = 1'b0;
    case (kind)
      alu8f_pkg::K_ADCW:  add16_ci = cin;
      alu8f_pkg::K_SUBW:  begin add16_b = ~operand_b; add16_ci = 1'b1; end
      alu8f_pkg::K_SBCW:  begin add16_b = ~operand_b; add16_ci = cin;  end
      alu8f_pkg::K_INCW:  add16_b = 16'd1;
      alu8f_pkg::K_ADCW1: begin add16_b = 16'd0;      add16_ci = cin;  end
      alu8f_pkg::K_SBCW1: begin add16_b = 16'hffff;   add16_ci = cin;  end
      alu8f_pkg::K_NEGW:  begin add16_a = ~operand_a; add16_b = 16'd1; end
      default: ;
    endcase
  end

  assign sum16 = {1'b0, add16_a} + {1'b0, add16_b} + {16'd0, add16_ci};
  assign ovf16 = (add16_a[15] & add16_b[15] & ~sum16[15])
               | (~add16_a[15] & ~add16_b[15] & sum16[15]);

  // mul takes the high byte of a, mad the low byte of b
  assign mul_b   = (kind == alu8f_pkg::K_MAD) ? bl : operand_a[15:8];
  assign prod    = {8'd0, al} * {8'd0, mul_b};
  assign mad_sum = prod + {8'd0, operand_c} + {15'd0, cin};

  assign rot_word = {al, al} << operand_c[2:0];
  assign inc8     = al + 8'd1;
  assign dec8     = al - 8'd1;
  assign merge8   = (al & operand_c) | (operand_a[15:8] & ~operand_c);

  always_comb begin
    result        = 16'd0;
    writes_result = 1'b1;
    flags_new     = flags_cur;
    case (kind)
      alu8f_pkg::K_ADD8, alu8f_pkg::K_ADC8, alu8f_pkg::K_SUB8,
      alu8f_pkg::K_SBC8, alu8f_pkg::K_CMP8: begin
        result      = {8'd0, sum8[7:0]};
        flags_new.z = (sum8[7:0] == 8'd0);
        flags_new.n = sum8[7];
        flags_new.c = sum8[8];
        flags_new.o = ovf8;
        flags_new.h = nib8[4];
        if (kind == alu8f_pkg::K_CMP8) begin
          writes_result = 1'b0;
        end
      end
      alu8f_pkg::K_OR8, alu8f_pkg::K_XOR8, alu8f_pkg::K_AND8: begin
        if (kind == alu8f_pkg::K_OR8) begin
          result = {8'd0, al | bl};
        end else if (kind == alu8f_pkg::K_XOR8) begin
          result = {8'd0, al ^ bl};
        end else begin
          result = {8'd0, al & bl};
        end
        flags_new.z = (result == 16'd0);
        flags_new.n = result[7];
      end
      alu8f_pkg::K_SRL: begin
        result      = {8'd0, 1'b0, al[7:1]};
        flags_new.c = al[0];
        flags_new.z = (al[7:1] == 7'd0);
      end
      alu8f_pkg::K_SLL: begin
        result      = {8'd0, al[6:0], 1'b0};
        flags_new.c = al[7];
        flags_new.z = (al[6:0] == 7'd0);
      end
      alu8f_pkg::K_RRC: begin
        result      = {8'd0, cin, al[7:1]};
        flags_new.c = al[0];
        flags_new.z = ({cin, al[7:1]} == 8'd0);
      end
      alu8f_pkg::K_RLC: begin
        result      = {8'd0, al[6:0], cin};
        flags_new.c = al[7];
        flags_new.z = ({al[6:0], cin} == 8'd0);
      end
      alu8f_pkg::K_INC: begin
        result      = {8'd0, inc8};
        flags_new.c = (inc8 == 8'd0);
        flags_new.z = (inc8 == 8'd0);
      end
      alu8f_pkg::K_DEC: begin
        result      = {8'd0, dec8};
        flags_new.c = (dec8 == 8'hff);
        flags_new.z = (dec8 == 8'd0);
      end
      alu8f_pkg::K_TST: begin
        result        = {8'd0, al};
        writes_result = 1'b0;
        flags_new.z   = (al == 8'd0);
        flags_new.n   = al[7];
        flags_new.c   = 1'b0;
        flags_new.o   = ~^al;
      end
      alu8f_pkg::K_SRA: begin
        result      = {8'd0, al[7], al[7:1]};
        flags_new.c = al[0];
      end
      alu8f_pkg::K_ROT:  result = {8'd0, rot_word[15:8]};
      alu8f_pkg::K_BOOL: begin
        result      = {15'd0, (al != 8'd0)};
        flags_new.z = (al == 8'd0);
      end
      alu8f_pkg::K_MSK:  result = {operand_a[15:8], merge8};
      alu8f_pkg::K_MUL: begin
        result      = prod;
        flags_new.z = (prod == 16'd0);
        flags_new.n = prod[15];
        flags_new.c = 1'b0;
      end
      alu8f_pkg::K_MAD: begin
        // 255*255 + 255 + 1 stays below 2^16, so no carry out
        result      = mad_sum;
        flags_new.c = 1'b0;
      end
      alu8f_pkg::K_ADDW, alu8f_pkg::K_ADCW, alu8f_pkg::K_SUBW, alu8f_pkg::K_SBCW,
      alu8f_pkg::K_INCW, alu8f_pkg::K_ADCW1, alu8f_pkg::K_SBCW1,
      alu8f_pkg::K_NEGW: begin
        result      = sum16[15:0];
        flags_new.z = (sum16[15:0] == 16'd0);
        flags_new.n = sum16[15];
        flags_new.c = sum16[16];
        flags_new.o = ovf16;
      end
      alu8f_pkg::K_ORW: begin
        result      = operand_a | operand_b;
        flags_new.z = ((operand_a | operand_b) == 16'd0);
        flags_new.n = operand_a[15] | operand_b[15];
      end
      alu8f_pkg::K_TSTW: begin
        result        = operand_a;
        writes_result = 1'b0;
        flags_new.z   = (operand_a == 16'd0);
        flags_new.n   = operand_a[15];
        flags_new.c   = 1'b1;
        flags_new.o   = ~^operand_a;
      end
      default: begin
        result        = 16'd0;
        writes_result = 1'b0;
      end
    endcase
  end

endmodule

@@ test/eight_bit_alu_with_flags_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eight_bit_alu_with_flags_core_test
// Self-checking bench for the flag-setting ALU. Directed words cover every
// operation, wrap-around, borrow, overflow, parity and the unused code; a long
// random mix follows with gaps and stalls on both sides. Each returned word is
// checked against a local prediction that tracks the flag register.
// ----------------------------------------------------------------------------
module eight_bit_alu_with_flags_core_test;

  localparam logic [4:0] KindUnused = 5'd31;
  localparam int QuietLimit = 2000;

  typedef struct packed {
    logic [15:0]       value;
    logic              wr;
    alu8f_pkg::flags_t fl;
  } alu_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_stall;
  logic [4:0]  kind = '0;
  logic [15:0] operand_a = '0;
  logic [15:0] operand_b = '0;
  logic [7:0]  operand_c = '0;
  logic        rsp_valid;
  logic        rsp_stall = 1'b0;
  logic [15:0] result;
  logic        writes_result;
  logic        flag_zero;
  logic        flag_negative;
  logic        flag_carry;
  logic        flag_overflow;
  logic        flag_half;

  alu_word_t         expected_words[$];
  alu_word_t         due_word;
  alu8f_pkg::flags_t flag_state = alu8f_pkg::FlagsClear;
  int                mismatches = 0;
  int                quiet_cycles = 0;
  int                stall_left = 0;
  bit                idle_on = 1'b1;
  bit                rsp_free = 1'b0;

  eight_bit_alu_with_flags_core dut (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .kind          (kind),
    .operand_a     (operand_a),
    .operand_b     (operand_b),
    .operand_c     (operand_c),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .result        (result),
    .writes_result (writes_result),
    .flag_zero     (flag_zero),
    .flag_negative (flag_negative),
    .flag_carry    (flag_carry),
    .flag_overflow (flag_overflow),
    .flag_half     (flag_half)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic alu_word_t add_byte(input logic [7:0] x, input logic [7:0] y,
                                         input logic cin, input alu8f_pkg::flags_t f);
    alu_word_t w;
    logic [8:0] s;
    logic [4:0] hs;
    s = {1'b0, x} + {1'b0, y} + {8'd0, cin};
    hs = {1'b0, x[3:0]} + {1'b0, y[3:0]} + {4'd0, cin};
    w.value = {8'h00, s[7:0]};
    w.wr = 1'b1;
    w.fl = f;
    w.fl.z = (s[7:0] == 8'h00);
    w.fl.n = s[7];
    w.fl.c = s[8];
    w.fl.o = (x[7] == y[7]) && (s[7] != x[7]);
    w.fl.h = hs[4];
    return w;
  endfunction

  // H is left alone by the word adders
  function automatic alu_word_t add_word(input logic [15:0] x, input logic [15:0] y,
                                         input logic cin, input alu8f_pkg::flags_t f);
    alu_word_t w;
    logic [16:0] s;
    s = {1'b0, x} + {1'b0, y} + {16'd0, cin};
    w.value = s[15:0];
    w.wr = 1'b1;
    w.fl = f;
    w.fl.z = (s[15:0] == 16'h0000);
    w.fl.n = s[15];
    w.fl.c = s[16];
    w.fl.o = (x[15] == y[15]) && (s[15] != x[15]);
    return w;
  endfunction

  function automatic alu_word_t predict_alu(input logic [4:0] k, input logic [15:0] a,
                                            input logic [15:0] b, input logic [7:0] oc,
                                            input alu8f_pkg::flags_t f);
    alu_word_t w;
    logic [7:0] al, ah, bl, r8;
    logic [15:0] dbl;
    logic [16:0] m;
    al = a[7:0];
    ah = a[15:8];
    bl = b[7:0];
    r8 = '0;
    w.value = '0;
    w.wr = 1'b1;
    w.fl = f;
    case (k)
      alu8f_pkg::K_ADD8: w = add_byte(al, bl, 1'b0, f);
      alu8f_pkg::K_ADC8: w = add_byte(al, bl, f.c, f);
      alu8f_pkg::K_SUB8: w = add_byte(al, ~bl, 1'b1, f);
      alu8f_pkg::K_SBC8: w = add_byte(al, ~bl, f.c, f);
      alu8f_pkg::K_CMP8: begin
        w = add_byte(al, ~bl, 1'b1, f);
        w.wr = 1'b0;
      end
      alu8f_pkg::K_OR8, alu8f_pkg::K_XOR8, alu8f_pkg::K_AND8: begin
        r8 = (k == alu8f_pkg::K_OR8) ? (al | bl) :
             (k == alu8f_pkg::K_XOR8) ? (al ^ bl) : (al & bl);
        w.value = {8'h00, r8};
        w.fl.z = (r8 == 8'h00);
        w.fl.n = r8[7];
      end
      alu8f_pkg::K_SRL, alu8f_pkg::K_SLL, alu8f_pkg::K_RRC, alu8f_pkg::K_RLC: begin
        case (k)
          alu8f_pkg::K_SRL: r8 = {1'b0, al[7:1]};
          alu8f_pkg::K_SLL: r8 = {al[6:0], 1'b0};
          alu8f_pkg::K_RRC: r8 = {f.c, al[7:1]};
          default:          r8 = {al[6:0], f.c};
        endcase
        w.value = {8'h00, r8};
        w.fl.c = (k == alu8f_pkg::K_SRL || k == alu8f_pkg::K_RRC) ? al[0] : al[7];
        w.fl.z = (r8 == 8'h00);
      end
      alu8f_pkg::K_INC: begin
        r8 = al + 8'd1;
        w.value = {8'h00, r8};
        w.fl.c = (r8 == 8'h00);
        w.fl.z = (r8 == 8'h00);
      end
      alu8f_pkg::K_DEC: begin
        r8 = al - 8'd1;
        w.value = {8'h00, r8};
        w.fl.c = (r8 == 8'hff);
        w.fl.z = (r8 == 8'h00);
      end
      alu8f_pkg::K_TST: begin
        w.value = {8'h00, al};
        w.wr = 1'b0;
        w.fl.z = (al == 8'h00);
        w.fl.n = al[7];
        w.fl.c = 1'b0;
        w.fl.o = ~^al;
      end
      alu8f_pkg::K_SRA: begin
        w.value = {8'h00, al[7], al[7:1]};
        w.fl.c = al[0];
      end
      alu8f_pkg::K_ROT: begin
        dbl = {al, al} << oc[2:0];
        w.value = {8'h00, dbl[15:8]};
      end
      alu8f_pkg::K_BOOL: begin
        w.value = {15'd0, (al != 8'h00)};
        w.fl.z = (al == 8'h00);
      end
      alu8f_pkg::K_MSK: w.value = {ah, (al & oc) | (ah & ~oc)};
      alu8f_pkg::K_MUL: begin
        w.value = {8'h00, al} * {8'h00, ah};
        w.fl.z = (w.value == 16'h0000);
        w.fl.n = w.value[15];
        w.fl.c = 1'b0;
      end
      alu8f_pkg::K_MAD: begin
        m = {9'd0, al} * {9'd0, bl} + {9'd0, oc} + {16'd0, f.c};
        w.value = m[15:0];
        w.fl.c = m[16];
      end
      alu8f_pkg::K_ADDW:  w = add_word(a, b, 1'b0, f);
      alu8f_pkg::K_ADCW:  w = add_word(a, b, f.c, f);
      alu8f_pkg::K_SUBW:  w = add_word(a, ~b, 1'b1, f);
      alu8f_pkg::K_SBCW:  w = add_word(a, ~b, f.c, f);
      alu8f_pkg::K_ORW: begin
        w.value = a | b;
        w.fl.z = (w.value == 16'h0000);
        w.fl.n = w.value[15];
      end
      alu8f_pkg::K_INCW:  w = add_word(a, 16'h0001, 1'b0, f);
      alu8f_pkg::K_ADCW1: w = add_word(a, 16'h0000, f.c, f);
      alu8f_pkg::K_SBCW1: w = add_word(a, 16'hffff, f.c, f);
      alu8f_pkg::K_TSTW: begin
        w.value = a;
        w.wr = 1'b0;
        w.fl.z = (a == 16'h0000);
        w.fl.n = a[15];
        w.fl.c = 1'b1;
        w.fl.o = ~^a;
      end
      alu8f_pkg::K_NEGW:  w = add_word(~a, 16'h0001, 1'b0, f);
      default: w.wr = 1'b0;
    endcase
    return w;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // lean towards the corner values of the adders
  function automatic logic [15:0] pick_operand();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return {$urandom_range(0, 1) ? 8'h80 : 8'h7f, 8'($urandom)};
      3:       return {8'($urandom), $urandom_range(0, 1) ? 8'h80 : 8'h7f};
      4:       return {8'($urandom), $urandom_range(0, 1) ? 8'hff : 8'h00};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [4:0] k, input logic [15:0] a,
                           input logic [15:0] b, input logic [7:0] oc);
    alu_word_t w;
    logic stalled;
    int gap;
    req_valid <= 1'b1;
    kind <= k;
    operand_a <= a;
    operand_b <= b;
    operand_c <= oc;
    do begin
      @(negedge clk);
      stalled = req_stall;
      @(posedge clk);
    end while (stalled);
    w = predict_alu(k, a, b, oc, flag_state);
    flag_state = w.fl;
    expected_words.push_back(w);
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender until every outstanding word is back
  task automatic results_drained();
    if (req_valid) req_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic report_field(input string what, input logic [15:0] want,
                              input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      rsp_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (rsp_free) begin
      rsp_stall <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          rsp_stall <= 1'b1;
          stall_left <= $urandom_range(0, 2);
        end
        5: begin
          rsp_stall <= 1'b1;
          stall_left <= $urandom_range(8, 30);
        end
        default: rsp_stall <= 1'b0;
      endcase
    end
  end

  // inputs change only at the rising edge, so the falling edge sees what the
  // next rising edge will accept
  always @(negedge clk) begin
    if (!rst) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (rsp_valid && !rsp_stall) begin
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected word, expected none, got result %h", $time, result);
          mismatches++;
        end else begin
          due_word = expected_words.pop_front();
          report_field("result", due_word.value, result);
          report_field("writes_result", {15'd0, due_word.wr}, {15'd0, writes_result});
          report_field("flag_zero", {15'd0, due_word.fl.z}, {15'd0, flag_zero});
          report_field("flag_negative", {15'd0, due_word.fl.n}, {15'd0, flag_negative});
          report_field("flag_carry", {15'd0, due_word.fl.c}, {15'd0, flag_carry});
          report_field("flag_overflow", {15'd0, due_word.fl.o}, {15'd0, flag_overflow});
          report_field("flag_half", {15'd0, due_word.fl.h}, {15'd0, flag_half});
        end
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic test_byte_arith();
    send_word(alu8f_pkg::K_ADD8, 16'h12ff, 16'hab01, 8'h00);
    send_word(alu8f_pkg::K_ADC8, 16'h0000, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_ADD8, 16'h007f, 16'h0001, 8'h00);
    send_word(alu8f_pkg::K_SUB8, 16'hff00, 16'h0001, 8'h00);
    send_word(alu8f_pkg::K_SBC8, 16'h0080, 16'h0001, 8'h00);
    send_word(alu8f_pkg::K_CMP8, 16'h0055, 16'hff55, 8'h00);
    send_word(alu8f_pkg::K_INC, 16'h00ff, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_DEC, 16'hff00, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_DEC, 16'h0001, 16'h0000, 8'h00);
  endtask

  task automatic test_byte_logic_shift();
    send_word(alu8f_pkg::K_OR8, 16'hff00, 16'hff00, 8'h00);
    send_word(alu8f_pkg::K_XOR8, 16'h00aa, 16'h0055, 8'h00);
    send_word(alu8f_pkg::K_AND8, 16'h0080, 16'h00ff, 8'h00);
    send_word(alu8f_pkg::K_SLL, 16'h0080, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_RRC, 16'h0001, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_RLC, 16'h0080, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_SRL, 16'hff01, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_SRA, 16'h0081, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_TST, 16'hff00, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_TST, 16'h0001, 16'h0000, 8'h00);
  endtask

  task automatic test_byte_misc();
    send_word(alu8f_pkg::K_ROT, 16'h0081, 16'h0000, 8'hff);
    send_word(alu8f_pkg::K_ROT, 16'h0081, 16'h0000, 8'h08);
    send_word(alu8f_pkg::K_BOOL, 16'hff00, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_BOOL, 16'h0040, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_MSK, 16'hf00f, 16'h0000, 8'h3c);
    send_word(alu8f_pkg::K_MUL, 16'hffff, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_MUL, 16'h00ff, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_SLL, 16'h0080, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_MAD, 16'h00ff, 16'hffff, 8'hff);
  endtask

  task automatic test_word_ops();
    send_word(alu8f_pkg::K_ADDW, 16'hffff, 16'h0001, 8'h00);
    send_word(alu8f_pkg::K_ADCW, 16'h7fff, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_SUBW, 16'h0000, 16'h0001, 8'h00);
    send_word(alu8f_pkg::K_SBCW, 16'h8000, 16'h0001, 8'h00);
    send_word(alu8f_pkg::K_ORW, 16'h0000, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_INCW, 16'hffff, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_ADCW1, 16'hffff, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_SBCW1, 16'h0000, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_TSTW, 16'h8001, 16'h0000, 8'h00);
    send_word(alu8f_pkg::K_NEGW, 16'h8000, 16'h0000, 8'h00);
  endtask

  task automatic test_unused_kind();
    send_word(KindUnused, 16'hffff, 16'hffff, 8'hff);
  endtask

  task automatic test_random_mix();
    int seg, i;
    logic [4:0] k;
    logic [15:0] a, b, cw;
    for (seg = 0; seg < 8; seg++) begin
      idle_on = (seg != 0) && ($urandom_range(0, 3) != 0);
      rsp_free = (seg == 0) || ($urandom_range(0, 3) == 0);
      for (i = 0; i < 250; i++) begin
        k = ($urandom_range(0, 63) == 0) ? KindUnused : 5'($urandom_range(0, 30));
        a = pick_operand();
        b = pick_operand();
        cw = pick_operand();
        send_word(k, a, b, cw[7:0]);
      end
      results_drained();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_byte_arith();
    test_byte_logic_shift();
    results_drained();
    test_byte_misc();
    test_word_ops();
    test_unused_kind();
    results_drained();
    test_random_mix();
    results_drained();
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
